>>> hw/rtl/fdcd_pkg.sv
// ----------------------------------------------------------------------------
// Framed digit command decoder package
// Shared widths, register indexes, frame states and result kinds.
// ----------------------------------------------------------------------------
package fdcd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned NibbleW = 4;
  localparam int unsigned RoomW   = 15;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CfgIdxW = 1;

  // Reset values of the configuration registers.
  localparam logic [ByteW-1:0] HeaderReset  = 8'h55;
  localparam logic [ByteW-1:0] TrailerReset = 8'h6B;

  // Decimal digit weights.
  localparam logic [RoomW-1:0] Weight1000 = 15'd1000;
  localparam logic [RoomW-1:0] Weight100  = 15'd100;
  localparam logic [RoomW-1:0] Weight10   = 15'd10;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegHeader  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegTrailer = 1'b1;

  // Position inside a frame.
  typedef enum logic [3:0] {
    FRAME_IDLE  = 4'b0001,
    FRAME_PAY1  = 4'b0010,
    FRAME_PAY2  = 4'b0100,
    FRAME_TRAIL = 4'b1000
  } frame_state_e;

  // Kind of update caused by a completed frame.
  typedef enum logic [KindW-1:0] {
    UPD_NONE   = 2'd0,
    UPD_TARGET = 2'd1,
    UPD_ROOM   = 2'd2
  } update_kind_e;

  // Status handed from the framer to the rest of the block.
  typedef struct packed {
    logic             done;
    logic [ByteW-1:0] pay1;
    logic [ByteW-1:0] pay2;
  } frame_t;

endpackage

>>> hw/rtl/fdcd_framer.sv
// ----------------------------------------------------------------------------
// Frame tracker
// Follows header, two payload bytes and trailer; flags a completed frame.
// ----------------------------------------------------------------------------
module fdcd_framer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [fdcd_pkg::ByteW-1:0]  byte_i,
  input  logic [fdcd_pkg::ByteW-1:0]  header_i,
  input  logic [fdcd_pkg::ByteW-1:0]  trailer_i,
  output fdcd_pkg::frame_t            frame_o
);

  fdcd_pkg::frame_state_e state_q, state_d;
  logic [fdcd_pkg::ByteW-1:0] pay1_q, pay2_q;

  // Next position. A wrong trailer returns to idle without checking for a header.
  always_comb begin
    state_d = state_q;
    if (step_i) begin
      unique case (state_q)
        fdcd_pkg::FRAME_IDLE: begin
          if (byte_i == header_i) state_d = fdcd_pkg::FRAME_PAY1;
        end
        fdcd_pkg::FRAME_PAY1:  state_d = fdcd_pkg::FRAME_PAY2;
        fdcd_pkg::FRAME_PAY2:  state_d = fdcd_pkg::FRAME_TRAIL;
        fdcd_pkg::FRAME_TRAIL: state_d = fdcd_pkg::FRAME_IDLE;
        default:               state_d = fdcd_pkg::FRAME_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdcd_pkg::FRAME_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Payload bytes are taken without any check.
  always_ff @(posedge clk_i) begin
    if (step_i && state_q == fdcd_pkg::FRAME_PAY1) pay1_q <= byte_i;
    if (step_i && state_q == fdcd_pkg::FRAME_PAY2) pay2_q <= byte_i;
  end

  assign frame_o.done = step_i && (state_q == fdcd_pkg::FRAME_TRAIL) && (byte_i == trailer_i);
  assign frame_o.pay1 = pay1_q;
  assign frame_o.pay2 = pay2_q;

endmodule

>>> hw/rtl/fdcd_decode.sv
// ----------------------------------------------------------------------------
// Nibble decoder
// Turns the four payload nibbles into a target or a decimal room number.
// ----------------------------------------------------------------------------
module fdcd_decode (
  input  logic [fdcd_pkg::ByteW-1:0]   pay1_i,
  input  logic [fdcd_pkg::ByteW-1:0]   pay2_i,
  input  logic [fdcd_pkg::NibbleW-1:0] target_i,
  input  logic [fdcd_pkg::RoomW-1:0]   room_i,
  output fdcd_pkg::update_kind_e       kind_o,
  output logic [fdcd_pkg::NibbleW-1:0] target_o,
  output logic [fdcd_pkg::RoomW-1:0]   room_o
);

  logic [fdcd_pkg::NibbleW-1:0] d1, d2, d3, d4;
  logic nz1, nz2, nz3, nz4;
  logic [fdcd_pkg::RoomW-1:0] room2, room3, room4;

  assign d1 = pay1_i[7:4];
  assign d2 = pay1_i[3:0];
  assign d3 = pay2_i[7:4];
  assign d4 = pay2_i[3:0];

  assign nz1 = (d1 != '0);
  assign nz2 = (d2 != '0);
  assign nz3 = (d3 != '0);
  assign nz4 = (d4 != '0);

  // Decimal values for two, three and four leading digits.
  assign room2 = fdcd_pkg::RoomW'(fdcd_pkg::RoomW'(d1) * fdcd_pkg::Weight10)
               + fdcd_pkg::RoomW'(d2);
  assign room3 = fdcd_pkg::RoomW'(fdcd_pkg::RoomW'(d1) * fdcd_pkg::Weight100)
               + fdcd_pkg::RoomW'(fdcd_pkg::RoomW'(d2) * fdcd_pkg::Weight10)
               + fdcd_pkg::RoomW'(d3);
  assign room4 = fdcd_pkg::RoomW'(fdcd_pkg::RoomW'(d1) * fdcd_pkg::Weight1000)
               + fdcd_pkg::RoomW'(fdcd_pkg::RoomW'(d2) * fdcd_pkg::Weight100)
               + fdcd_pkg::RoomW'(fdcd_pkg::RoomW'(d3) * fdcd_pkg::Weight10)
               + fdcd_pkg::RoomW'(d4);

  // Only a run of nonzero leading digits followed by zeros is decoded.
  always_comb begin
    kind_o   = fdcd_pkg::UPD_NONE;
    target_o = target_i;
    room_o   = room_i;
    priority if (!nz1) begin
      kind_o = fdcd_pkg::UPD_NONE;
    end else if (!nz2 && !nz3 && !nz4) begin
      kind_o   = fdcd_pkg::UPD_TARGET;
      target_o = d1;
    end else if (nz2 && !nz3 && !nz4) begin
      kind_o = fdcd_pkg::UPD_ROOM;
      room_o = room2;
    end else if (nz2 && nz3 && !nz4) begin
      kind_o = fdcd_pkg::UPD_ROOM;
      room_o = room3;
    end else if (nz2 && nz3 && nz4) begin
      kind_o = fdcd_pkg::UPD_ROOM;
      room_o = room4;
    end else begin
      kind_o = fdcd_pkg::UPD_NONE;
    end
  end

endmodule

>>> hw/rtl/framed_digit_command_decoder.sv
// ----------------------------------------------------------------------------
// Framed digit command decoder
// Finds header/payload/payload/trailer byte frames and decodes their digits.
// ----------------------------------------------------------------------------
// Each received byte is taken into an input register and then handled by the
// frame tracker and the nibble decoder, whose result lands in an output
// register, so one byte can be accepted in every cycle while the output
// register is free or being taken. Only a completed frame with the right
// trailer gives a result; it carries the kind of update and the target and
// room number as they stand after the frame. Both stores reset to zero and
// the frame position to idle; header and trailer reset to 0x55 and 0x6B and
// may be rewritten while the block is idle.
module framed_digit_command_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fdcd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [fdcd_pkg::ByteW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [fdcd_pkg::ByteW-1:0]   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fdcd_pkg::KindW-1:0]   update_kind_o,
  output logic [fdcd_pkg::NibbleW-1:0] target_value_o,
  output logic [fdcd_pkg::RoomW-1:0]   room_value_o
);

  logic [fdcd_pkg::ByteW-1:0]   header_q, trailer_q;
  logic                         rx_valid_q;
  logic [fdcd_pkg::ByteW-1:0]   rx_byte_q;
  logic                         advance;
  fdcd_pkg::frame_t             frame;
  fdcd_pkg::update_kind_e       kind_d, kind_q;
  logic [fdcd_pkg::NibbleW-1:0] target_d, target_q;
  logic [fdcd_pkg::RoomW-1:0]   room_d, room_q;
  logic                         out_valid_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= fdcd_pkg::HeaderReset;
      trailer_q <= fdcd_pkg::TrailerReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fdcd_pkg::RegHeader:  header_q  <= cfg_data_i;
        fdcd_pkg::RegTrailer: trailer_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole pipe moves when the output register is empty or being taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid_q <= 1'b0;
    end else if (advance) begin
      rx_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) rx_byte_q <= rx_byte_i;
  end

  fdcd_framer u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance && rx_valid_q),
    .byte_i    (rx_byte_q),
    .header_i  (header_q),
    .trailer_i (trailer_q),
    .frame_o   (frame)
  );

  fdcd_decode u_decode (
    .pay1_i   (frame.pay1),
    .pay2_i   (frame.pay2),
    .target_i (target_q),
    .room_i   (room_q),
    .kind_o   (kind_d),
    .target_o (target_d),
    .room_o   (room_d)
  );

  // Result register and the target and room stores. The stores change only
  // when a frame completes, which needs a free output register, so they also
  // serve as the held result fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      kind_q      <= fdcd_pkg::UPD_NONE;
      target_q    <= '0;
      room_q      <= '0;
    end else if (advance) begin
      out_valid_q <= frame.done;
      if (frame.done) begin
        kind_q   <= kind_d;
        target_q <= target_d;
        room_q   <= room_d;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign update_kind_o  = kind_q;
  assign target_value_o = target_q;
  assign room_value_o   = room_q;

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Framed digit command decoder testbench
// Streams received bytes into the decoder and compares every frame result
// against a cycle-free prediction of the frame tracker and the digit decoder.
// The run covers directed corner frames, then randomized frames under several
// header/trailer settings, with idling on both channels and one long output
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned PhaseItems = 440;

  // Tracks frame position and the two stores, and queues the result that each
  // completed frame should produce.
  class command_scoreboard;
    typedef struct {
      fdcd_pkg::update_kind_e       kind;
      logic [fdcd_pkg::NibbleW-1:0] target;
      logic [fdcd_pkg::RoomW-1:0]   room;
    } update_t;

    logic [fdcd_pkg::ByteW-1:0]   header;
    logic [fdcd_pkg::ByteW-1:0]   trailer;
    fdcd_pkg::frame_state_e       position;
    logic [fdcd_pkg::ByteW-1:0]   pay1;
    logic [fdcd_pkg::ByteW-1:0]   pay2;
    logic [fdcd_pkg::NibbleW-1:0] target;
    logic [fdcd_pkg::RoomW-1:0]   room;
    update_t                      pending_updates[$];
    int                           error_count;

    function new();
      header      = fdcd_pkg::HeaderReset;
      trailer     = fdcd_pkg::TrailerReset;
      position    = fdcd_pkg::FRAME_IDLE;
      pay1        = '0;
      pay2        = '0;
      target      = '0;
      room        = '0;
      error_count = 0;
    endfunction

    function void write_reg(logic [fdcd_pkg::CfgIdxW-1:0] idx,
                            logic [fdcd_pkg::ByteW-1:0] val);
      case (idx)
        fdcd_pkg::RegHeader:  header = val;
        fdcd_pkg::RegTrailer: trailer = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_updates.size();
    endfunction

    // Splits the payload into four digits and updates the stores.
    function fdcd_pkg::update_kind_e decode_digits();
      logic [fdcd_pkg::NibbleW-1:0] d1;
      logic [fdcd_pkg::NibbleW-1:0] d2;
      logic [fdcd_pkg::NibbleW-1:0] d3;
      logic [fdcd_pkg::NibbleW-1:0] d4;
      d1 = pay1[7:4];
      d2 = pay1[3:0];
      d3 = pay2[7:4];
      d4 = pay2[3:0];
      if (d1 == 0) return fdcd_pkg::UPD_NONE;
      if (d2 == 0 && d3 == 0 && d4 == 0) begin
        target = d1;
        return fdcd_pkg::UPD_TARGET;
      end
      if (d2 != 0 && d3 == 0 && d4 == 0) begin
        room = d1 * fdcd_pkg::Weight10 + d2;
        return fdcd_pkg::UPD_ROOM;
      end
      if (d2 != 0 && d3 != 0 && d4 == 0) begin
        room = d1 * fdcd_pkg::Weight100 + d2 * fdcd_pkg::Weight10 + d3;
        return fdcd_pkg::UPD_ROOM;
      end
      if (d2 != 0 && d3 != 0 && d4 != 0) begin
        room = d1 * fdcd_pkg::Weight1000 + d2 * fdcd_pkg::Weight100
             + d3 * fdcd_pkg::Weight10 + d4;
        return fdcd_pkg::UPD_ROOM;
      end
      return fdcd_pkg::UPD_NONE;
    endfunction

    // Advances the frame tracker by one accepted byte.
    function void take_rx_byte(logic [fdcd_pkg::ByteW-1:0] b);
      update_t u;
      case (position)
        fdcd_pkg::FRAME_IDLE: begin
          if (b == header) position = fdcd_pkg::FRAME_PAY1;
        end
        fdcd_pkg::FRAME_PAY1: begin
          pay1     = b;
          position = fdcd_pkg::FRAME_PAY2;
        end
        fdcd_pkg::FRAME_PAY2: begin
          pay2     = b;
          position = fdcd_pkg::FRAME_TRAIL;
        end
        default: begin
          // A wrong trailer just drops the frame; it is never taken as a header.
          position = fdcd_pkg::FRAME_IDLE;
          if (b == trailer) begin
            u.kind   = decode_digits();
            u.target = target;
            u.room   = room;
            pending_updates.push_back(u);
          end
        end
      endcase
    endfunction

    function void check_update(logic [fdcd_pkg::KindW-1:0] kind,
                               logic [fdcd_pkg::NibbleW-1:0] tgt,
                               logic [fdcd_pkg::RoomW-1:0] rm);
      update_t u;
      if (pending_updates.size() == 0) begin
        $error("result with no frame waiting: kind %0d target %0d room %0d",
               kind, tgt, rm);
        error_count++;
        return;
      end
      u = pending_updates.pop_front();
      if (kind !== u.kind) begin
        $error("update_kind: expected %0d, actual %0d", u.kind, kind);
        error_count++;
      end
      if (tgt !== u.target) begin
        $error("target_value: expected %0d, actual %0d", u.target, tgt);
        error_count++;
      end
      if (rm !== u.room) begin
        $error("room_value: expected %0d, actual %0d", u.room, rm);
        error_count++;
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [fdcd_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [fdcd_pkg::ByteW-1:0]   cfg_data_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [fdcd_pkg::ByteW-1:0]   rx_byte_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [fdcd_pkg::KindW-1:0]   update_kind_o;
  logic [fdcd_pkg::NibbleW-1:0] target_value_o;
  logic [fdcd_pkg::RoomW-1:0]   room_value_o;

  command_scoreboard sb = new();

  int unsigned                send_idle_pct = 31;
  int unsigned                recv_stall_pct = 78;
  int unsigned                hold_requests = 0;
  int unsigned                cycle_count = 0;
  logic [fdcd_pkg::ByteW-1:0] cur_header = fdcd_pkg::HeaderReset;
  logic [fdcd_pkg::ByteW-1:0] cur_trailer = fdcd_pkg::TrailerReset;

  framed_digit_command_decoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .update_kind_o  (update_kind_o),
    .target_value_o (target_value_o),
    .room_value_o   (room_value_o)
  );

  // Clock with an 8 ns period.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Both channels are sampled at the clock edge, before any new drive lands.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_update(update_kind_o, target_value_o, room_value_o);
      end
      if (in_valid_i && !in_stall_o) begin
        sb.take_rx_byte(rx_byte_i);
      end
    end
  end

  // Output side: random stall, or a long hold-off whenever one is requested.
  initial begin
    int unsigned hold_left;
    int unsigned hold_served;
    hold_left   = 0;
    hold_served = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_served != hold_requests) begin
        hold_served++;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Offers one byte, possibly after an idle gap, and waits until it is taken.
  task automatic send_byte(input logic [fdcd_pkg::ByteW-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Picks two payload bytes whose digits lean toward the decodable patterns.
  function automatic logic [2*fdcd_pkg::ByteW-1:0] pick_digits();
    logic [fdcd_pkg::NibbleW-1:0] d[4];
    int unsigned                  lead;
    lead = 0;
    case ($urandom_range(0, 9))
      0, 1: lead = 1;
      2, 3: lead = 2;
      4, 5: lead = 3;
      6, 7: lead = 4;
      8: begin
        for (int i = 0; i < 4; i++) begin
          d[i] = $urandom_range(0, 1) ? fdcd_pkg::NibbleW'($urandom_range(1, 15)) : '0;
        end
        return {d[0], d[1], d[2], d[3]};
      end
      default: return 16'($urandom());
    endcase
    for (int i = 0; i < 4; i++) begin
      d[i] = (i < lead) ? fdcd_pkg::NibbleW'($urandom_range(1, 15)) : '0;
    end
    return {d[0], d[1], d[2], d[3]};
  endfunction

  // Sends one four-byte frame, closed by the right trailer or a wrong one.
  task automatic send_frame(input bit good_trailer);
    logic [2*fdcd_pkg::ByteW-1:0] digits;
    logic [fdcd_pkg::ByteW-1:0]   closing;
    digits  = pick_digits();
    closing = cur_trailer;
    if (!good_trailer) begin
      do begin
        closing = ($urandom_range(0, 3) == 0) ? cur_header
                : fdcd_pkg::ByteW'($urandom_range(0, 255));
      end while (closing == cur_trailer);
    end
    send_byte(cur_header);
    send_byte(digits[15:8]);
    send_byte(digits[7:0]);
    send_byte(closing);
  endtask

  // Lets every expected result arrive and the pipeline empty out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes the header framing register and then the trailer one.
  task automatic write_framing(input logic [fdcd_pkg::ByteW-1:0] h,
                               input logic [fdcd_pkg::ByteW-1:0] t);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= fdcd_pkg::RegHeader;
    cfg_data_i  <= h;
    @(posedge clk_i);
    sb.write_reg(fdcd_pkg::RegHeader, h);
    cfg_index_i <= fdcd_pkg::RegTrailer;
    cfg_data_i  <= t;
    @(posedge clk_i);
    sb.write_reg(fdcd_pkg::RegTrailer, t);
    cfg_we_i    <= 1'b0;
    cur_header  = h;
    cur_trailer = t;
  endtask

  // One randomized phase: mostly good frames, some broken ones, some noise.
  task automatic run_phase(input logic [fdcd_pkg::ByteW-1:0] h,
                           input logic [fdcd_pkg::ByteW-1:0] t,
                           input int unsigned send_pct, input int unsigned recv_pct,
                           input bit hold_off);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    drain();
    write_framing(h, t);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (hold_off) hold_requests++;
    while (sent < PhaseItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_frame(1'b1);
        sent += 4;
      end else if (pick < 85) begin
        send_frame(1'b0);
        sent += 4;
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(fdcd_pkg::ByteW'($urandom_range(0, 255)));
      end
    end
  endtask

  // Directed corner bytes under the reset framing values.
  logic [fdcd_pkg::ByteW-1:0] corner_bytes[] = '{
    8'h00, 8'hFF,                  // dropped while idle
    8'h55, 8'h70, 8'h00, 8'h6B,    // target only
    8'h55, 8'hFF, 8'hFF, 8'h6B,    // largest room number
    8'h55, 8'h55, 8'h55, 8'h6B,    // header value inside the payload
    8'h55, 8'h12, 8'h34, 8'h55,    // wrong trailer equal to the header
    8'h55, 8'hF9, 8'h00, 8'h6B,    // two-digit room number
    8'h55, 8'h10, 8'h10, 8'h6B     // undecodable digit pattern
  };

  initial begin
    logic [fdcd_pkg::ByteW-1:0] shared_value;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= fdcd_pkg::RegHeader;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    rx_byte_i   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_bytes[i]) send_byte(corner_bytes[i]);

    // Framing extremes, then random values, then header equal to trailer.
    run_phase(8'h00, 8'hFF, 31, 78, 1'b0);
    run_phase(8'hFF, 8'h00, 78, 31, 1'b0);
    run_phase(fdcd_pkg::ByteW'($urandom_range(0, 255)),
              fdcd_pkg::ByteW'($urandom_range(0, 255)), 0, 0, 1'b1);
    shared_value = fdcd_pkg::ByteW'($urandom_range(0, 255));
    run_phase(shared_value, shared_value, 0, 0, 1'b0);

    drain();
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
